FILE: hdl/dht_pkg.sv
// Shared constants, types and helper functions for the double hash table.
package dht_pkg;

  localparam int TABLE_SLOTS = 10;
  localparam int STEP_PRIME  = 7;

  localparam int KEY_W    = 31;
  localparam int NAME_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int ENTRY_W  = KEY_W + NAME_W;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  // Residue registers hold values below twice the larger modulus.
  localparam int MAX_MOD = (TABLE_SLOTS > STEP_PRIME) ? TABLE_SLOTS : STEP_PRIME;
  localparam int RES_W   = $clog2(MAX_MOD) + 1;

  // The key is reduced one nibble per cycle, most significant nibble first.
  localparam int HASH_STEPS = (KEY_W + 3) / 4;
  localparam int SH_W       = HASH_STEPS * 4;
  localparam int STEP_W     = $clog2(STEP_PRIME + 1);
  localparam int STEP_NIBS  = (STEP_W + 3) / 4;
  localparam int STEP_PAD   = STEP_NIBS * 4;
  localparam int CYC_W      = $clog2(HASH_STEPS);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_SLOT   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name_handle;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [NAME_W-1:0]   found_name;
  } out_t;

  typedef struct packed {
    logic    load_in;
    logic    hash_run;
    logic    step_load;
    logic    step_run;
    logic    advance;
    logic    ins_write;
    logic    res_load;
    status_t res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lookup;
    logic full;
    logic slot_free;
    logic key_match;
    logic last_probe;
  } dp_stat_t;

  // Folds four more bits into a residue modulo m; each bit is one
  // shift and one conditional subtract.
  function automatic logic [RES_W-1:0] mod_nib(input logic [RES_W-1:0] r,
                                               input logic [3:0]       nib,
                                               input logic [RES_W-1:0] m);
    logic [RES_W-1:0] acc;
    acc = r;
    for (int k = 3; k >= 0; k--) begin
      acc = {acc[RES_W-2:0], nib[k]};
      if (acc >= m) begin
        acc = acc - m;
      end
    end
    return acc;
  endfunction

endpackage

FILE: hdl/double_hash_table.sv
// Top level of the open-addressing hash table with double hashing.
// An item is taken at a clock edge where start is high and busy is low; busy
// stays high until its result is ready, and one item is worked on at a time.
// Every item gives exactly one result, shown on out_item for a single cycle
// with out_valid high; the receiver cannot stall, so it must take the
// transfer in that cycle. The next item may be started in that same cycle.
// From the accepting edge, the hash state reduces the key modulo the table
// size and the step prime a nibble at a time, and the step load and step run
// states then prepare the probe step. Then an insert probes one slot per
// cycle (occupancy is in flip-flops), and a lookup takes a probe state and a
// check state per occupied slot it compares, since each stored key comes
// from the slot RAM with a registered read. The result strobe is registered
// and comes in the cycle after the deciding probe.
module double_hash_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dht_pkg::in_t  in_item,
  output logic          out_valid,
  output dht_pkg::out_t out_item
);

  dht_pkg::ctrl_cmd_t cmd;
  dht_pkg::dp_stat_t  stat;

  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dht_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

FILE: hdl/dht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/dht_ctrl.sv
// Controller state machine that sequences hashing, probing and the result strobe.
module dht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  dht_pkg::dp_stat_t   stat,
  output dht_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_STEP_LD,
    S_STEP_RUN,
    S_PROBE,
    S_CHECK
  } state_t;

  state_t                    state_r, state_nxt;
  logic [dht_pkg::CYC_W-1:0] cyc_r, cyc_nxt;
  logic                      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    cyc_nxt        = cyc_r;
    cmd            = '0;
    cmd.res_status = dht_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          cyc_nxt     = '0;
          state_nxt   = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_run = 1'b1;
        if (cyc_r == dht_pkg::CYC_W'(dht_pkg::HASH_STEPS - 1)) begin
          cyc_nxt   = '0;
          state_nxt = S_STEP_LD;
        end else begin
          cyc_nxt = cyc_r + 1'b1;
        end
      end
      S_STEP_LD: begin
        cmd.step_load = 1'b1;
        state_nxt     = S_STEP_RUN;
      end
      S_STEP_RUN: begin
        cmd.step_run = 1'b1;
        if (cyc_r == dht_pkg::CYC_W'(dht_pkg::STEP_NIBS - 1)) begin
          state_nxt = S_PROBE;
        end else begin
          cyc_nxt = cyc_r + 1'b1;
        end
      end
      S_PROBE: begin
        if (!stat.lookup) begin
          if (stat.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = dht_pkg::ST_FULL;
            state_nxt      = S_IDLE;
          end else if (stat.slot_free) begin
            cmd.ins_write  = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = dht_pkg::ST_OK;
            state_nxt      = S_IDLE;
          end else if (stat.last_probe) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = dht_pkg::ST_NO_SLOT;
            state_nxt      = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          if (stat.slot_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = dht_pkg::ST_NOT_FOUND;
            state_nxt      = S_IDLE;
          end else begin
            // The slot's stored entry is read now and compared next cycle.
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = dht_pkg::ST_OK;
          state_nxt      = S_IDLE;
        end else if (stat.last_probe) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = dht_pkg::ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_PROBE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cyc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hdl/dht_dp.sv
// Datapath: serial hash reduction, probe address stepping, slot store and result register.
module dht_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dht_pkg::in_t       in_item,
  input  dht_pkg::ctrl_cmd_t cmd,
  output dht_pkg::dp_stat_t  stat,
  output dht_pkg::out_t      out_item
);

  logic                         func_r;
  logic [dht_pkg::KEY_W-1:0]    key_r;
  logic [dht_pkg::NAME_W-1:0]   name_r;
  logic [dht_pkg::SH_W-1:0]     sh_r;
  logic [dht_pkg::RES_W-1:0]    home_r;
  logic [dht_pkg::RES_W-1:0]    kp_r;
  logic [dht_pkg::RES_W-1:0]    stepm_r;
  logic [dht_pkg::IDX_W-1:0]    addr_r;
  logic [dht_pkg::IDX_W-1:0]    probe_r;
  logic [dht_pkg::TABLE_SLOTS-1:0] valid_r;
  logic [dht_pkg::CNT_W-1:0]    count_r;
  dht_pkg::out_t                res_r;

  logic [3:0]                   nib;
  logic [dht_pkg::STEP_PAD-1:0] step_val;
  logic [dht_pkg::IDX_W:0]      addr_sum;
  logic [dht_pkg::IDX_W-1:0]    addr_nxt;
  logic [dht_pkg::ENTRY_W-1:0]  rd_entry;
  logic                         res_ok;

  assign nib      = sh_r[dht_pkg::SH_W-1 -: 4];
  assign step_val = dht_pkg::STEP_PAD'(dht_pkg::STEP_PRIME) - dht_pkg::STEP_PAD'(kp_r);

  // Both terms are below the table size, so one subtract wraps the sum.
  assign addr_sum = {1'b0, addr_r} + (dht_pkg::IDX_W + 1)'(stepm_r);
  always_comb begin
    if (addr_sum >= (dht_pkg::IDX_W + 1)'(dht_pkg::TABLE_SLOTS)) begin
      addr_nxt = dht_pkg::IDX_W'(addr_sum - (dht_pkg::IDX_W + 1)'(dht_pkg::TABLE_SLOTS));
    end else begin
      addr_nxt = addr_sum[dht_pkg::IDX_W-1:0];
    end
  end

  dht_ram #(
    .WIDTH (dht_pkg::ENTRY_W),
    .DEPTH (dht_pkg::TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (addr_r),
    .wdata ({key_r, name_r}),
    .raddr (addr_r),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_item.func;
      key_r  <= in_item.key;
      name_r <= in_item.name_handle;
      sh_r   <= dht_pkg::SH_W'(in_item.key);
      home_r <= '0;
      kp_r   <= '0;
    end else if (cmd.hash_run) begin
      sh_r   <= sh_r << 4;
      home_r <= dht_pkg::mod_nib(home_r, nib, dht_pkg::RES_W'(dht_pkg::TABLE_SLOTS));
      kp_r   <= dht_pkg::mod_nib(kp_r, nib, dht_pkg::RES_W'(dht_pkg::STEP_PRIME));
    end else if (cmd.step_load) begin
      // The probe step is reduced modulo the table size the same way.
      sh_r    <= {step_val, {(dht_pkg::SH_W - dht_pkg::STEP_PAD){1'b0}}};
      stepm_r <= '0;
      addr_r  <= dht_pkg::IDX_W'(home_r);
      probe_r <= '0;
    end else if (cmd.step_run) begin
      sh_r    <= sh_r << 4;
      stepm_r <= dht_pkg::mod_nib(stepm_r, nib, dht_pkg::RES_W'(dht_pkg::TABLE_SLOTS));
    end else if (cmd.advance) begin
      addr_r  <= addr_nxt;
      probe_r <= probe_r + 1'b1;
    end
    if (cmd.res_load) begin
      res_r.status     <= cmd.res_status;
      res_r.slot       <= res_ok ? dht_pkg::SLOT_W'(addr_r) : '0;
      res_r.found_name <= (res_ok && func_r == dht_pkg::FUNC_LOOKUP) ?
                          rd_entry[dht_pkg::NAME_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.ins_write) begin
      valid_r[addr_r] <= 1'b1;
      count_r         <= count_r + 1'b1;
    end
  end

  assign res_ok = (cmd.res_status == dht_pkg::ST_OK);

  assign stat.lookup     = (func_r == dht_pkg::FUNC_LOOKUP);
  assign stat.full       = (count_r == dht_pkg::CNT_W'(dht_pkg::TABLE_SLOTS));
  assign stat.slot_free  = !valid_r[addr_r];
  assign stat.key_match  = (rd_entry[dht_pkg::ENTRY_W-1:dht_pkg::NAME_W] == key_r);
  assign stat.last_probe = (probe_r == dht_pkg::IDX_W'(dht_pkg::TABLE_SLOTS - 1));

  assign out_item = res_r;

endmodule

FILE: tb/tb_double_hash_table.sv
// Self-checking testbench for the double hashing table: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_double_hash_table;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1525;

  logic           clk     = 1'b0;
  logic           rst_n   = 1'b0;
  logic           start   = 1'b0;
  dht_pkg::in_t   in_item = '0;
  logic           busy;
  logic           out_valid;
  dht_pkg::out_t  out_item;

  // Shadow copy of the table contents.
  logic [dht_pkg::KEY_W-1:0]  model_key  [dht_pkg::TABLE_SLOTS];
  logic [dht_pkg::NAME_W-1:0] model_name [dht_pkg::TABLE_SLOTS];
  bit                         model_used [dht_pkg::TABLE_SLOTS];
  int                         model_count;

  dht_pkg::out_t expected_replies[$];
  int            mismatches;
  int            items_sent;
  int            status_seen [4];
  int            stall_cycles;
  bit            no_idle;

  double_hash_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  function automatic int unsigned probe_slot(input logic [dht_pkg::KEY_W-1:0] key,
                                             input int unsigned i);
    int unsigned home;
    int unsigned stride;
    home   = key % dht_pkg::TABLE_SLOTS;
    stride = dht_pkg::STEP_PRIME - (key % dht_pkg::STEP_PRIME);
    return (home + stride * i) % dht_pkg::TABLE_SLOTS;
  endfunction

  // Applies one operation to the shadow table and returns the reply it should give.
  function automatic dht_pkg::out_t predict_table_op(input dht_pkg::in_t item);
    dht_pkg::out_t r;
    int unsigned   a;
    int unsigned   i;
    bit            done;
    r    = '0;
    done = 1'b0;
    if (item.func == dht_pkg::FUNC_INSERT) begin
      if (model_count >= dht_pkg::TABLE_SLOTS) begin
        r.status = dht_pkg::ST_FULL;
      end else begin
        r.status = dht_pkg::ST_NO_SLOT;
        for (i = 0; i < dht_pkg::TABLE_SLOTS && !done; i++) begin
          a = probe_slot(item.key, i);
          if (!model_used[a]) begin
            model_used[a] = 1'b1;
            model_key[a]  = item.key;
            model_name[a] = item.name_handle;
            model_count++;
            r.status = dht_pkg::ST_OK;
            r.slot   = a[dht_pkg::SLOT_W-1:0];
            done     = 1'b1;
          end
        end
      end
    end else begin
      r.status = dht_pkg::ST_NOT_FOUND;
      for (i = 0; i < dht_pkg::TABLE_SLOTS && !done; i++) begin
        a = probe_slot(item.key, i);
        if (!model_used[a]) begin
          done = 1'b1;
        end else if (model_key[a] == item.key) begin
          r.status     = dht_pkg::ST_OK;
          r.slot       = a[dht_pkg::SLOT_W-1:0];
          r.found_name = model_name[a];
          done         = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Presents one operation and returns at the edge where its transfer happens.
  task automatic send_item(input logic func, input logic [dht_pkg::KEY_W-1:0] key,
                           input logic [dht_pkg::NAME_W-1:0] name);
    dht_pkg::in_t item;
    int           gap;
    item.func        = func;
    item.key         = key;
    item.name_handle = name;
    if (!no_idle && $urandom_range(99) < 37) begin
      start   <= 1'b0;
      in_item <= dht_pkg::in_t'({$urandom, $urandom});
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 35) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_replies.push_back(predict_table_op(item));
    status_seen[expected_replies[$].status]++;
    items_sent++;
  endtask

  // Every reply is compared with the oldest pending prediction.
  always @(posedge clk) begin
    dht_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: reply with nothing pending: status=%0d slot=%0d name=%h",
                   out_item.status, out_item.slot, out_item.found_name);
        end
      end else begin
        want = expected_replies.pop_front();
        if (out_item.status !== want.status || out_item.slot !== want.slot ||
            out_item.found_name !== want.found_name) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: expected status=%0d slot=%0d name=%h, got status=%0d slot=%0d name=%h",
                     want.status, want.slot, want.found_name,
                     out_item.status, out_item.slot, out_item.found_name);
          end
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_empty_lookup();
    send_item(dht_pkg::FUNC_LOOKUP, '0, $urandom);
    send_item(dht_pkg::FUNC_LOOKUP, {dht_pkg::KEY_W{1'b1}}, {dht_pkg::NAME_W{1'b1}});
  endtask

  // Key zero is an ordinary key; the extremes of key and name are stored and read back.
  task automatic test_extremes();
    send_item(dht_pkg::FUNC_INSERT, '0, {dht_pkg::NAME_W{1'b1}});
    send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'(5), '0);
    send_item(dht_pkg::FUNC_LOOKUP, '0, '0);
    send_item(dht_pkg::FUNC_LOOKUP, dht_pkg::KEY_W'(5), {dht_pkg::NAME_W{1'b1}});
    send_item(dht_pkg::FUNC_INSERT, {dht_pkg::KEY_W{1'b1}}, 32'hA5A5_5A5A);
    send_item(dht_pkg::FUNC_LOOKUP, {dht_pkg::KEY_W{1'b1}}, $urandom);
  endtask

  // Key 30 has home slot 0 and stride 5, so it only ever visits slots 0 and 5.
  task automatic test_no_free_slot();
    send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'(30), $urandom);
    send_item(dht_pkg::FUNC_LOOKUP, dht_pkg::KEY_W'(30), $urandom);
    send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'(40), $urandom);
    send_item(dht_pkg::FUNC_LOOKUP, dht_pkg::KEY_W'(40), '0);
  endtask

  task automatic test_duplicate_key();
    send_item(dht_pkg::FUNC_INSERT, '0, 32'h1234_5678);
    send_item(dht_pkg::FUNC_LOOKUP, '0, '0);
    send_item(dht_pkg::FUNC_INSERT, {dht_pkg::KEY_W{1'b1}}, 32'h0BAD_F00D);
    send_item(dht_pkg::FUNC_LOOKUP, {dht_pkg::KEY_W{1'b1}}, '0);
  endtask

  // Keys congruent to 6 mod 7 step by one, so they always find a free slot.
  task automatic test_fill_to_full();
    int tries;
    tries = 0;
    while (model_count < dht_pkg::TABLE_SLOTS && tries < 20) begin
      if (tries[0]) begin
        send_item(dht_pkg::FUNC_INSERT,
                  dht_pkg::KEY_W'(7 * $urandom_range(0, 300000000) + 6), $urandom);
      end else begin
        send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'($urandom), $urandom);
      end
      tries++;
    end
    send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'($urandom), $urandom);
    send_item(dht_pkg::FUNC_LOOKUP, dht_pkg::KEY_W'(30), $urandom);
  endtask

  task automatic test_random_traffic();
    int                        pick;
    int                        idx;
    logic [dht_pkg::KEY_W-1:0] key;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 500 && n < 800);
      pick = $urandom_range(99);
      idx  = $urandom_range(dht_pkg::TABLE_SLOTS - 1);
      if (pick < 45 && model_used[idx]) begin
        send_item(dht_pkg::FUNC_LOOKUP, model_key[idx], $urandom);
      end else if (pick < 60 && model_used[idx]) begin
        key = model_key[idx] ^
              (dht_pkg::KEY_W'(1) << $urandom_range(dht_pkg::KEY_W - 1));
        send_item(dht_pkg::FUNC_LOOKUP, key, $urandom);
      end else if (pick < 80) begin
        send_item(dht_pkg::FUNC_LOOKUP, dht_pkg::KEY_W'($urandom), $urandom);
      end else begin
        send_item(dht_pkg::FUNC_INSERT, dht_pkg::KEY_W'($urandom), $urandom);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    model_count = 0;
    mismatches  = 0;
    items_sent  = 0;
    no_idle     = 1'b0;
    foreach (model_used[i]) model_used[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_lookup();
    test_extremes();
    test_no_free_slot();
    test_duplicate_key();
    test_fill_to_full();
    test_random_traffic();

    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) mismatches++;

    $display("Sent %0d operations: %0d ok, %0d full, %0d no free slot, %0d not found.",
             items_sent, status_seen[dht_pkg::ST_OK], status_seen[dht_pkg::ST_FULL],
             status_seen[dht_pkg::ST_NO_SLOT], status_seen[dht_pkg::ST_NOT_FOUND]);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: double_hash_table.f
hdl/dht_pkg.sv
hdl/dht_ram.sv
hdl/dht_ctrl.sv
hdl/dht_dp.sv
hdl/double_hash_table.sv
tb/tb_double_hash_table.sv
